// ----- hw/rtl/sawc_pkg.sv -----
`default_nettype none
package sawc_pkg;

  localparam int ADDR_W  = 52;
  localparam int DATA_W  = 64;
  localparam int MADDR_W = 46;

  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_FILL   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] KIND_RDATA    = 2'd0;
  localparam logic [1:0] KIND_WDONE    = 2'd1;
  localparam logic [1:0] KIND_WBACK    = 2'd2;
  localparam logic [1:0] KIND_FILL_REQ = 2'd3;

  localparam logic [1:0] LS_INVALID = 2'd0;
  localparam logic [1:0] LS_CLEAN   = 2'd1;
  localparam logic [1:0] LS_DIRTY   = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_HIT,
    ST_WB_RD,
    ST_WB_OUT,
    ST_REQ,
    ST_FILL_RD,
    ST_FILL_WR
  } state_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
    logic [DATA_W-1:0] fill_data;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         rdata;
    logic               hit;
    logic               evicted;
    logic [MADDR_W-1:0] mem_addr;
    logic [DATA_W-1:0]  mem_data;
    logic [2:0]         word_index;
    logic               last;
  } out_t;

endpackage
`default_nettype wire

// ----- hw/rtl/set_assoc_writeback_cache_core.sv -----
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_ready | sawc_pkg::in_t  (cmd, addr, wdata, fill_data)
// rsp     | out       | rsp_valid/rsp_ready | sawc_pkg::out_t (kind .. last)
//
// Hit: accept, then the tag/age read of the set memory, then the data word read.
// Miss: accept, lookup, a data read and an output per written-back word, then the fill request.
// Fill word: written as it is accepted; after the last one of a line, data read, then merge and write.
// After reset a clearing pass writes every set row, with req_ready low.
// A busy rsp register stalls the sequencer in its output state; one result in flight.
`default_nettype none
module set_assoc_writeback_cache_core #(
  parameter int OFFSET_BITS = 6,
  parameter int INDEX_BITS  = 6,
  parameter int WAYS        = 8,
  parameter int AGE_BITS    = 16,
  parameter int ADDR_BITS   = 52
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire sawc_pkg::in_t  req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output sawc_pkg::out_t      rsp
);
  import sawc_pkg::*;

  localparam int NSETS    = 1 << INDEX_BITS;
  localparam int WPL      = 1 << (OFFSET_BITS - 3);
  localparam int TAG_BITS = ADDR_BITS - OFFSET_BITS - INDEX_BITS;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WORD_W   = (OFFSET_BITS > 3) ? OFFSET_BITS - 3 : 1;
  localparam int DEPTH    = NSETS * WAYS * WPL;
  localparam int DA_W     = $clog2(DEPTH);
  localparam logic [63:0] ADDR_MASK =
    (ADDR_BITS >= 64) ? {64{1'b1}} : ((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [1:0]          st;
    logic [AGE_BITS-1:0] age;
  } way_t;
  typedef way_t [WAYS-1:0] row_t;

  function automatic logic [INDEX_BITS-1:0] set_of(input logic [ADDR_W-1:0] a);
    set_of = INDEX_BITS'(a >> OFFSET_BITS);
  endfunction
  function automatic logic [TAG_BITS-1:0] tag_of(input logic [ADDR_W-1:0] a);
    tag_of = TAG_BITS'(64'(a) >> (OFFSET_BITS + INDEX_BITS));
  endfunction
  function automatic logic [WORD_W-1:0] word_of(input logic [ADDR_W-1:0] a);
    word_of = WORD_W'(a >> 3) & WORD_W'(WPL - 1);
  endfunction
  function automatic logic [DA_W-1:0] da(input logic [INDEX_BITS-1:0] s,
                                         input logic [WAY_W-1:0] w,
                                         input logic [WORD_W-1:0] k);
    da = DA_W'((32'(s) * WAYS + 32'(w)) * WPL + 32'(k));
  endfunction
  function automatic logic [DATA_W-1:0] merge(input logic [DATA_W-1:0] d,
                                              input logic [2:0] lane,
                                              input logic [7:0] b);
    merge = (d & ~(64'hFF << {lane, 3'b000})) | (64'(b) << {lane, 3'b000});
  endfunction

  // memories
  row_t              meta_mem [NSETS];
  row_t              meta_q;
  logic [DATA_W-1:0] data_mem [DEPTH];
  logic [DATA_W-1:0] dq;

  state_t state, state_next;
  logic [INDEX_BITS-1:0] clr_idx;
  in_t                   cur;
  logic [INDEX_BITS-1:0] set_r;
  logic [WAY_W-1:0]      way_r;
  logic                  pend, pend_wr;
  logic [ADDR_W-1:0]     pend_addr;
  logic [7:0]            pend_byte;
  logic [WAY_W-1:0]      pend_way;
  logic [WORD_W-1:0]     fill_cnt, wcnt;
  logic [TAG_BITS-1:0]   vic_tag;
  logic                  vic_valid;

  logic [INDEX_BITS-1:0] meta_raddr, meta_waddr;
  logic                  meta_we;
  row_t                  meta_wdata;
  logic [DA_W-1:0]       da_raddr, da_waddr;
  logic                  da_we;
  logic [DATA_W-1:0]     da_wdata;
  logic                  out_load, out_free;
  out_t                  out_next;

  // lookup results
  logic [WAYS-1:0]     hitv;
  logic                hit_any, have_inv;
  logic [WAY_W-1:0]    hit_way, inv_way, old_way, vic_way;
  logic [AGE_BITS-1:0] best;
  row_t                aged, upd;
  logic [ADDR_W-1:0]   in_addr;

  assign in_addr  = req.addr & ADDR_MASK[ADDR_W-1:0];
  assign out_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE);

  always_comb begin
    hit_any  = 1'b0;
    hit_way  = '0;
    have_inv = 1'b0;
    inv_way  = '0;
    old_way  = '0;
    best     = '0;
    aged     = meta_q;
    for (int w = 0; w < WAYS; w++) begin
      aged[w].age = (meta_q[w].age == AGE_MAX) ? meta_q[w].age
                                               : meta_q[w].age + AGE_BITS'(1);
      hitv[w] = (meta_q[w].st != LS_INVALID) && (meta_q[w].tag == tag_of(cur.addr));
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hitv[w]) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (meta_q[w].st == LS_INVALID) begin
        have_inv = 1'b1;
        inv_way  = WAY_W'(w);
      end
      if (w == 0 || aged[w].age > best) begin
        best    = aged[w].age;
        old_way = WAY_W'(w);
      end
    end
    vic_way = have_inv ? inv_way : old_way;
    upd = aged;
    if (hit_any) begin
      upd[hit_way].age = '0;
      if (cur.cmd == CMD_WRITE) upd[hit_way].st = LS_DIRTY;
    end else begin
      upd[vic_way].age = '0;
      upd[vic_way].st  = LS_INVALID;
    end
  end

  always_comb begin
    state_next = state;
    meta_raddr = (state == ST_IDLE) ?
                 ((req.cmd == CMD_FILL) ? set_of(pend_addr) : set_of(in_addr)) : set_r;
    meta_we    = 1'b0;
    meta_waddr = set_r;
    meta_wdata = upd;
    da_raddr   = da(set_r, way_r, word_of(cur.addr));
    da_we      = 1'b0;
    da_waddr   = da(set_r, way_r, word_of(cur.addr));
    da_wdata   = merge(dq, cur.addr[2:0], cur.wdata);
    out_load   = 1'b0;
    out_next   = '0;
    case (state)
      ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_idx;
        meta_wdata = '0;
        if (clr_idx == INDEX_BITS'(NSETS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          if ((req.cmd == CMD_READ || req.cmd == CMD_WRITE) && !pend) begin
            state_next = ST_LOOKUP;
          end else if (req.cmd == CMD_FILL && pend) begin
            da_we    = 1'b1;
            da_waddr = da(set_of(pend_addr), pend_way, fill_cnt);
            da_wdata = req.fill_data;
            if (fill_cnt == WORD_W'(WPL - 1)) state_next = ST_FILL_RD;
          end
        end
      end
      ST_LOOKUP: begin
        meta_we  = 1'b1;
        da_raddr = da(set_r, hit_way, word_of(cur.addr));
        if (hit_any) state_next = ST_HIT;
        else if (meta_q[vic_way].st == LS_DIRTY) state_next = ST_WB_RD;
        else state_next = ST_REQ;
      end
      ST_HIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_next.hit = 1'b1;
          out_next.last = 1'b1;
          if (cur.cmd == CMD_WRITE) begin
            out_next.kind = KIND_WDONE;
            da_we = 1'b1;
          end else begin
            out_next.kind  = KIND_RDATA;
            out_next.rdata = 8'(dq >> {cur.addr[2:0], 3'b000});
          end
          state_next = ST_IDLE;
        end
      end
      ST_WB_RD, ST_WB_OUT: begin
        da_raddr = da(set_r, pend_way, wcnt);
        if (state == ST_WB_RD) begin
          state_next = ST_WB_OUT;
        end else if (out_free) begin
          out_load            = 1'b1;
          out_next.kind       = KIND_WBACK;
          out_next.evicted    = 1'b1;
          out_next.mem_addr   = MADDR_W'((64'(vic_tag) << INDEX_BITS) | 64'(set_r));
          out_next.mem_data   = dq;
          out_next.word_index = 3'(wcnt);
          state_next = (wcnt == WORD_W'(WPL - 1)) ? ST_REQ : ST_WB_RD;
        end
      end
      ST_REQ: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_next.kind     = KIND_FILL_REQ;
          out_next.evicted  = vic_valid;
          out_next.mem_addr = MADDR_W'(pend_addr >> OFFSET_BITS);
          out_next.last     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FILL_RD, ST_FILL_WR: begin
        da_raddr = da(set_r, pend_way, word_of(pend_addr));
        da_waddr = da_raddr;
        da_wdata = merge(dq, pend_addr[2:0], pend_byte);
        meta_wdata = meta_q;
        meta_wdata[pend_way].tag = tag_of(pend_addr);
        meta_wdata[pend_way].st  = pend_wr ? LS_DIRTY : LS_CLEAN;
        if (state == ST_FILL_RD) begin
          state_next = ST_FILL_WR;
        end else if (out_free) begin
          out_load      = 1'b1;
          meta_we       = 1'b1;
          out_next.last = 1'b1;
          if (pend_wr) begin
            out_next.kind = KIND_WDONE;
            da_we = 1'b1;
          end else begin
            out_next.kind  = KIND_RDATA;
            out_next.rdata = 8'(dq >> {pend_addr[2:0], 3'b000});
          end
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    meta_q <= meta_mem[meta_raddr];
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
    dq <= data_mem[da_raddr];
    if (da_we) data_mem[da_waddr] <= da_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      pend      <= 1'b0;
      pend_wr   <= 1'b0;
      pend_addr <= '0;
      pend_byte <= '0;
      pend_way  <= '0;
      fill_cnt  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_idx <= clr_idx + INDEX_BITS'(1);
      if (out_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      if (state == ST_IDLE && req_valid && req.cmd == CMD_FILL && pend) begin
        fill_cnt <= (fill_cnt == WORD_W'(WPL - 1)) ? '0 : fill_cnt + WORD_W'(1);
      end
      if (state == ST_LOOKUP && !hit_any) begin
        pend      <= 1'b1;
        pend_wr   <= (cur.cmd == CMD_WRITE);
        pend_addr <= cur.addr;
        pend_byte <= cur.wdata;
        pend_way  <= vic_way;
        fill_cnt  <= '0;
      end
      if (state == ST_FILL_WR && out_free) pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) rsp <= out_next;
    if (state == ST_IDLE && req_valid) begin
      cur   <= '{cmd: req.cmd, addr: in_addr, wdata: req.wdata, fill_data: req.fill_data};
      set_r <= (req.cmd == CMD_FILL) ? set_of(pend_addr) : set_of(in_addr);
    end
    if (state == ST_LOOKUP) begin
      way_r     <= hit_way;
      vic_tag   <= meta_q[vic_way].tag;
      vic_valid <= (meta_q[vic_way].st != LS_INVALID);
      wcnt      <= '0;
    end
    if (state == ST_WB_OUT && out_free) wcnt <= wcnt + WORD_W'(1);
  end

  // a tag is never installed twice in one set
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOOKUP |-> $onehot0(hitv))
    else $error("more than one way hit");

  a_clear_no_miss: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !pend)
    else $error("miss pending during clearing pass");

  a_req_marks_pending: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_next.kind == KIND_FILL_REQ) |=> pend)
    else $error("fill request without pending miss");

endmodule
`default_nettype wire

// ----- sim/sawc_scoreboard.sv -----
`default_nettype none
module sawc_scoreboard (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  input  wire logic           req_ready,
  input  wire sawc_pkg::in_t  req,
  input  wire logic           rsp_valid,
  input  wire logic           rsp_ready,
  input  wire sawc_pkg::out_t rsp,
  output int                  errors,
  output logic                miss_open,
  output int                  outstanding
);
  import sawc_pkg::*;

  localparam int OFF_W = 6;
  localparam int IDX_W = 6;
  localparam int NWAY  = 8;
  localparam int WPL   = 8;
  localparam int TAG_W = ADDR_W - OFF_W - IDX_W;
  localparam int NLINE = (1 << IDX_W) * NWAY;

  logic [TAG_W-1:0]  tag_mem [NLINE];
  logic [1:0]        state_mem [NLINE];
  logic [15:0]       age_mem [NLINE];
  logic [DATA_W-1:0] word_mem [NLINE*WPL];
  bit                pend;
  bit                pend_write;
  logic [ADDR_W-1:0] pend_addr;
  logic [7:0]        pend_byte;
  int                pend_way;
  int                fill_cnt;
  out_t              due_rsp [$];
  int                nerr;

  task automatic cache_step(input in_t it);
    logic [OFF_W-1:0] off;
    logic [IDX_W-1:0] set;
    logic [TAG_W-1:0] tg;
    logic [15:0]      best;
    int               base, line, victim, inv, oldest, wi;
    bit               have_inv, was_valid;
    out_t             r;
    r = '0;
    if (it.cmd == CMD_FILL) begin
      if (!pend) return;
      off  = pend_addr[OFF_W-1:0];
      set  = pend_addr[OFF_W +: IDX_W];
      line = set * NWAY + pend_way;
      word_mem[line*WPL + fill_cnt] = it.fill_data;
      if (fill_cnt < WPL - 1) begin
        fill_cnt++;
        return;
      end
      fill_cnt = 0;
      pend = 0;
      tag_mem[line] = pend_addr[ADDR_W-1 -: TAG_W];
      r.last = 1'b1;
      if (pend_write) begin
        word_mem[line*WPL + off[5:3]][off[2:0]*8 +: 8] = pend_byte;
        state_mem[line] = LS_DIRTY;
        r.kind = KIND_WDONE;
      end else begin
        state_mem[line] = LS_CLEAN;
        r.kind  = KIND_RDATA;
        r.rdata = word_mem[line*WPL + off[5:3]][off[2:0]*8 +: 8];
      end
      due_rsp.push_back(r);
      return;
    end
    if (it.cmd == CMD_UNUSED || pend) return;

    off  = it.addr[OFF_W-1:0];
    set  = it.addr[OFF_W +: IDX_W];
    tg   = it.addr[ADDR_W-1 -: TAG_W];
    base = set * NWAY;
    for (int w = 0; w < NWAY; w++)
      if (age_mem[base+w] != 16'hffff) age_mem[base+w]++;

    for (int w = 0; w < NWAY; w++) begin
      line = base + w;
      if (state_mem[line] != LS_INVALID && tag_mem[line] == tg) begin
        age_mem[line] = '0;
        r.hit  = 1'b1;
        r.last = 1'b1;
        if (it.cmd == CMD_WRITE) begin
          word_mem[line*WPL + off[5:3]][off[2:0]*8 +: 8] = it.wdata;
          state_mem[line] = LS_DIRTY;
          r.kind = KIND_WDONE;
        end else begin
          r.kind  = KIND_RDATA;
          r.rdata = word_mem[line*WPL + off[5:3]][off[2:0]*8 +: 8];
        end
        due_rsp.push_back(r);
        return;
      end
    end

    have_inv = 0;
    inv = 0;
    oldest = 0;
    best = '0;
    for (int w = 0; w < NWAY; w++) begin
      if (state_mem[base+w] == LS_INVALID) begin
        have_inv = 1;
        inv = w;
      end
      if (w == 0 || age_mem[base+w] > best) begin
        best = age_mem[base+w];
        oldest = w;
      end
    end
    victim = have_inv ? inv : oldest;
    line = base + victim;
    was_valid = state_mem[line] != LS_INVALID;
    if (state_mem[line] == LS_DIRTY) begin
      for (wi = 0; wi < WPL; wi++) begin
        r = '0;
        r.kind       = KIND_WBACK;
        r.evicted    = 1'b1;
        r.mem_addr   = {tag_mem[line], set};
        r.mem_data   = word_mem[line*WPL + wi];
        r.word_index = wi[2:0];
        due_rsp.push_back(r);
      end
    end
    r = '0;
    r.kind     = KIND_FILL_REQ;
    r.evicted  = was_valid;
    r.mem_addr = it.addr[ADDR_W-1:OFF_W];
    r.last     = 1'b1;
    due_rsp.push_back(r);
    state_mem[line] = LS_INVALID;
    age_mem[line]   = '0;
    pend       = 1;
    pend_write = it.cmd == CMD_WRITE;
    pend_addr  = it.addr;
    pend_byte  = it.wdata;
    pend_way   = victim;
    fill_cnt   = 0;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      for (int i = 0; i < NLINE; i++) begin
        state_mem[i] = LS_INVALID;
        age_mem[i]   = '0;
      end
      pend = 0;
      fill_cnt = 0;
      due_rsp.delete();
      nerr = 0;
    end else begin
      if (req_valid && req_ready) cache_step(req);
      if (rsp_valid && rsp_ready) begin
        if (due_rsp.size() == 0) begin
          nerr++;
          if (nerr <= 10)
            $display("unexpected result: kind %0d addr %h", rsp.kind, rsp.mem_addr);
        end else begin
          want = due_rsp.pop_front();
          if (rsp !== want) begin
            nerr++;
            if (nerr <= 10)
              $display({"mismatch: exp kind %0d rd %h hit %b ev %b ma %h md %h wi %0d last %b",
                        " / got kind %0d rd %h hit %b ev %b ma %h md %h wi %0d last %b"},
                       want.kind, want.rdata, want.hit, want.evicted, want.mem_addr,
                       want.mem_data, want.word_index, want.last,
                       rsp.kind, rsp.rdata, rsp.hit, rsp.evicted, rsp.mem_addr,
                       rsp.mem_data, rsp.word_index, rsp.last);
          end
        end
      end
    end
    errors      <= nerr;
    miss_open   <= pend;
    outstanding <= due_rsp.size();
  end

endmodule
`default_nettype wire

// ----- sim/set_assoc_writeback_cache_core_tb.sv -----
`default_nettype none
module set_assoc_writeback_cache_core_tb;
  import sawc_pkg::*;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  in_t  req;
  logic rsp_valid;
  logic rsp_ready;
  out_t rsp;
  int   errors;
  logic miss_open;
  int   outstanding;

  int idle_pct;
  int stall_pct;
  int n_sent;
  logic [39:0] tag_pool [12];

  set_assoc_writeback_cache_core u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  sawc_scoreboard u_scoreboard (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .errors(errors), .miss_open(miss_open), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("set_assoc_writeback_cache_core test failed");
    $finish;
  end

  always @(posedge clk) rsp_ready <= $urandom_range(99) >= stall_pct;

  // valid stays high between back-to-back items; caller drops it
  task automatic send_item(input logic [1:0] cmd, input logic [51:0] addr,
                           input logic [7:0] wdata, input logic [63:0] fdata);
    if ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    req.cmd       <= cmd;
    req.addr      <= addr;
    req.wdata     <= wdata;
    req.fill_data <= fdata;
    req_valid     <= 1'b1;
    do @(posedge clk); while (!req_ready);
    n_sent++;
  endtask

  task automatic send_fills(input int n);
    repeat (n) send_item(CMD_FILL, 52'({$urandom, $urandom}), 8'($urandom),
                         {$urandom, $urandom});
  endtask

  // access, then complete the line if it missed; now and then an access
  // is slipped into the middle of the fill
  task automatic access(input logic [1:0] cmd, input logic [51:0] addr);
    int k;
    send_item(cmd, addr, 8'($urandom), {$urandom, $urandom});
    req_valid <= 1'b0;
    @(posedge clk);
    if (miss_open) begin
      if ($urandom_range(15) == 0) begin
        k = $urandom_range(7);
        send_fills(k);
        send_item(2'($urandom_range(1)), 52'({$urandom, $urandom}), 8'($urandom), '0);
        send_fills(8 - k);
      end else begin
        send_fills(8);
      end
    end
  endtask

  function automatic logic [51:0] pick_addr();
    logic [5:0] set;
    case ($urandom_range(3))
      0: set = 6'd0;
      1: set = 6'd63;
      2: set = 6'd21;
      default: set = 6'($urandom);
    endcase
    return {tag_pool[$urandom_range(11)], set, 6'($urandom)};
  endfunction

  initial begin
    int r;
    bit paused;
    req_valid = 1'b0;
    req       = '0;
    rsp_ready = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    n_sent    = 0;
    paused    = 1'b0;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 12; i++) tag_pool[i] = 40'({$urandom, $urandom});
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed
    send_item(CMD_UNUSED, '1, 8'hff, '1);
    send_item(CMD_FILL, '0, '0, '1);
    access(CMD_READ, 52'h0);
    access(CMD_READ, 52'h3f);
    access(CMD_WRITE, 52'h7);
    access(CMD_READ, 52'h7);
    access(CMD_WRITE, '1);
    access(CMD_READ, '1);
    send_item(CMD_READ, 52'h40, 8'h00, '0);
    req_valid <= 1'b0;
    @(posedge clk);
    send_item(CMD_WRITE, 52'h80, 8'hff, '0);
    send_fills(8);
    for (int t = 0; t < 10; t++) access(CMD_WRITE, {tag_pool[t], 6'd5, 6'($urandom)});

    // random
    while (n_sent < 430) begin
      idle_pct  = (n_sent / 108 == 1) ? 78 : (n_sent / 108 == 3) ? 7 : 0;
      stall_pct = (n_sent / 108 == 2) ? 78 : (n_sent / 108 == 3) ? 7 : 0;
      if (!paused && n_sent >= 200) begin
        paused = 1'b1;
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
      end
      r = $urandom_range(99);
      if (r < 86) access(2'($urandom_range(1)), pick_addr());
      else if (r < 92) send_item(CMD_FILL, 52'({$urandom, $urandom}), 8'($urandom),
                                 {$urandom, $urandom});
      else if (r < 96) send_item(CMD_UNUSED, 52'({$urandom, $urandom}), 8'($urandom),
                                 {$urandom, $urandom});
      else access(2'($urandom_range(1)), 52'({$urandom, $urandom}));
    end
    req_valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (40) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("set_assoc_writeback_cache_core test passed");
    else
      $display("set_assoc_writeback_cache_core test failed");
    $finish;
  end

endmodule
`default_nettype wire
